[rtl/core/row_run_start_end_encoder_defines.svh]
// Assertion helpers shared by the encoder RTL.
`ifndef ROW_RUN_START_END_ENCODER_DEFINES_SVH
`define ROW_RUN_START_END_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RRSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrse same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RRSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrse next-cycle check failed");

`endif

[rtl/core/rrse_pkg.sv]
package rrse_pkg;

    // Configuration register layout
    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Output record
    localparam int VALUE_W = 14;
    localparam logic [VALUE_W-1:0] VALUE_BREAK = 14'h3FFF;

    typedef enum logic [2:0] {
        KIND_WIDTH  = 3'd0,
        KIND_HEIGHT = 3'd1,
        KIND_START  = 3'd2,
        KIND_END    = 3'd3,
        KIND_BREAK  = 3'd4
    } t_kind;

    // Records owed by one pixel, in emission order (MSB first)
    typedef struct packed {
        logic hdr_w;     // width header
        logic hdr_h;     // height header
        logic start;     // run start at col
        logic end_prev;  // run end at col-1
        logic end_last;  // run closed at last column
        logic brk;       // row break
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/core/row_run_start_end_encoder.sv]
// Path: an accepted pixel that owes records is written into the request queue; its
//   first record then moves to the output register, which the receiver takes when it does not stall.
// Throughput: one pixel per cycle while each pixel owes at most one record and the
//   receiver does not stall; a pixel owing more records holds the back end until all
//   are sent, one per unstalled cycle, and a 4-entry request queue absorbs the bursts.
// Reset (synchronous, active low): counters, run flag, queue and output valid cleared;
//   image_width = 640, image_height = 480.

module row_run_start_end_encoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel channel
    input  logic                                 i_pixel_valid,
    output logic                                 o_pixel_stall,
    input  logic [7:0]                           i_pixel,
    // record channel
    output logic                                 o_record_valid,
    input  logic                                 i_record_stall,
    output logic [2:0]                           o_record_kind,
    output logic signed [rrse_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_last,
    // APB-style configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // column/row counters hold values up to the max size minus one;
    // the effective sizes need one more code for the max itself
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int DW = rrse_pkg::FLAGS_W + WB;

    logic [rrse_pkg::CFG_W-1:0] r_image_width, r_image_height;
    logic [31:0]                w_ext, h_ext;
    logic [WB-1:0]              eff_w;
    logic [HB-1:0]              eff_h;
    logic                       cfg_wr;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rrse_pkg::WIDTH_RESET;
            r_image_height <= rrse_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                rrse_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= pwdata[rrse_pkg::CFG_W-1:0];
                end
                rrse_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= pwdata[rrse_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rrse_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            rrse_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:                    prdata = '0;
        endcase
    end

    // Effective sizes: zero acts as one, oversize clamps to the max.
    // These also feed the header records.
    assign w_ext = 32'(r_image_width);
    assign h_ext = 32'(r_image_height);

    always_comb begin
        if (w_ext == 32'd0) begin
            eff_w = WB'(1);
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            eff_w = WB'(MAX_WIDTH);
        end else begin
            eff_w = WB'(w_ext);
        end
        if (h_ext == 32'd0) begin
            eff_h = HB'(1);
        end else if (h_ext > 32'(MAX_HEIGHT)) begin
            eff_h = HB'(MAX_HEIGHT);
        end else begin
            eff_h = HB'(h_ext);
        end
    end

    // ---------------- front: accept and classify ----------------
    logic                 push, pop;
    rrse_pkg::t_flags     push_flags, head_flags;
    logic [WB-1:0]        push_col, head_col;
    logic [DW-1:0]        q_wdata, q_rdata;
    rrse_pkg::t_q_status  q_status;

    rrse_front #(
        .WB (WB),
        .HB (HB)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .i_pixel       (i_pixel),
        .o_pixel_stall (o_pixel_stall),
        .i_eff_w       (eff_w),
        .i_eff_h       (eff_h),
        .i_q_full      (q_status.full),
        .o_push        (push),
        .o_flags       (push_flags),
        .o_col         (push_col)
    );

    // ---------------- request queue ----------------
    // one entry per pixel that owes records: flags plus column
    assign q_wdata = {push_flags, push_col};

    rrse_queue #(
        .WIDTH (DW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (q_wdata),
        .i_pop    (pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    assign head_flags = q_rdata[DW-1:WB];
    assign head_col   = q_rdata[WB-1:0];

    // ---------------- back: record sequencer + output register ----------------
    rrse_back #(
        .WB (WB),
        .HB (HB)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_flags        (head_flags),
        .i_col          (head_col),
        .i_eff_w        (eff_w),
        .i_eff_h        (eff_h),
        .o_pop          (pop),
        .o_record_valid (o_record_valid),
        .i_record_stall (i_record_stall),
        .o_record_kind  (o_record_kind),
        .o_value        (o_value),
        .o_last         (o_last)
    );

endmodule

[rtl/core/rrse_queue.sv]
`include "row_run_start_end_encoder_defines.svh"

module rrse_queue #(
    parameter int WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output rrse_pkg::t_q_status   o_status
);

    logic [WIDTH-1:0]                r_mem [rrse_pkg::QUEUE_DEPTH];
    logic [rrse_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [rrse_pkg::QCNT_W-1:0]     r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == rrse_pkg::QCNT_W'(rrse_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    `RRSE_ASSERT_NOW(a_q_no_push_full, i_clk, i_rst_n, o_status.full, !i_push)
    `RRSE_ASSERT_NOW(a_q_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

[rtl/core/rrse_front.sv]
`include "row_run_start_end_encoder_defines.svh"

module rrse_front #(
    parameter int WB = 13,
    parameter int HB = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pixel_valid,
    input  logic [7:0]          i_pixel,
    output logic                o_pixel_stall,
    input  logic [WB-1:0]       i_eff_w,
    input  logic [HB-1:0]       i_eff_h,
    input  logic                i_q_full,
    output logic                o_push,
    output rrse_pkg::t_flags    o_flags,
    output logic [WB-1:0]       o_col
);

    logic [WB-1:0] r_col, n_col;
    logic [HB-1:0] r_row, n_row;
    logic          r_in_run, n_in_run;
    logic          accept, fg, row_end, img_end;

    assign o_pixel_stall = i_q_full;
    assign accept        = i_pixel_valid && !i_q_full;
    assign fg            = (i_pixel != 8'd0);
    assign row_end       = (r_col >= i_eff_w - WB'(1));
    assign img_end       = (r_row >= i_eff_h - HB'(1));

    always_comb begin
        o_flags.hdr_w    = (r_col == '0) && (r_row == '0);
        o_flags.hdr_h    = o_flags.hdr_w;
        o_flags.start    = fg && !r_in_run;
        o_flags.end_prev = !fg && r_in_run;
        o_flags.end_last = row_end && fg;
        o_flags.brk      = row_end;

        n_in_run = fg && !row_end;
        n_col    = row_end ? '0 : r_col + 1'b1;
        n_row    = r_row;
        if (row_end) begin
            n_row = img_end ? '0 : r_row + 1'b1;
        end
    end

    assign o_col  = r_col;
    // quiet pixels carry no records and skip the queue
    assign o_push = accept && (o_flags != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_in_run <= 1'b0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_in_run <= n_in_run;
        end
    end

    `RRSE_ASSERT_NEXT(a_fr_run_closed, i_clk, i_rst_n, accept && row_end, !r_in_run && r_col == '0)

endmodule

[rtl/core/rrse_back.sv]
`include "row_run_start_end_encoder_defines.svh"

module rrse_back #(
    parameter int WB = 13,
    parameter int HB = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrse_pkg::t_q_status           i_q_status,
    input  rrse_pkg::t_flags              i_flags,
    input  logic [WB-1:0]                 i_col,
    input  logic [WB-1:0]                 i_eff_w,
    input  logic [HB-1:0]                 i_eff_h,
    output logic                          o_pop,
    output logic                          o_record_valid,
    input  logic                          i_record_stall,
    output logic [2:0]                    o_record_kind,
    output logic signed [rrse_pkg::VALUE_W-1:0] o_value,
    output logic                          o_last
);

    rrse_pkg::t_flags               r_done, pend, sel, rest;
    logic                           r_valid, load;
    rrse_pkg::t_kind                sel_kind;
    logic [rrse_pkg::VALUE_W-1:0]   sel_value;
    logic [2:0]                     r_kind;
    logic [rrse_pkg::VALUE_W-1:0]   r_value;
    logic                           r_last;

    assign pend = i_flags & ~r_done;

    // lowest pending record in emission order
    always_comb begin
        sel       = '0;
        sel_kind  = rrse_pkg::KIND_BREAK;
        sel_value = rrse_pkg::VALUE_BREAK;
        if (pend.hdr_w) begin
            sel.hdr_w = 1'b1;
            sel_kind  = rrse_pkg::KIND_WIDTH;
            sel_value = rrse_pkg::VALUE_W'(i_eff_w);
        end else if (pend.hdr_h) begin
            sel.hdr_h = 1'b1;
            sel_kind  = rrse_pkg::KIND_HEIGHT;
            sel_value = rrse_pkg::VALUE_W'(i_eff_h);
        end else if (pend.start) begin
            sel.start = 1'b1;
            sel_kind  = rrse_pkg::KIND_START;
            sel_value = rrse_pkg::VALUE_W'(i_col);
        end else if (pend.end_prev) begin
            sel.end_prev = 1'b1;
            sel_kind     = rrse_pkg::KIND_END;
            sel_value    = rrse_pkg::VALUE_W'(i_col - WB'(1));
        end else if (pend.end_last) begin
            sel.end_last = 1'b1;
            sel_kind     = rrse_pkg::KIND_END;
            sel_value    = rrse_pkg::VALUE_W'(i_col);
        end else begin
            sel.brk = 1'b1;
        end
        rest = pend & ~sel;
    end

    assign load  = !i_q_status.empty && (!r_valid || !i_record_stall);
    assign o_pop = load && (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_record_stall) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= sel_kind;
            r_value <= sel_value;
            r_last  <= (rest == '0);
        end
    end

    assign o_record_valid = r_valid;
    assign o_record_kind  = r_kind;
    assign o_value        = signed'(r_value);
    assign o_last         = r_last;

    `RRSE_ASSERT_NEXT(a_bk_pop_is_last, i_clk, i_rst_n, o_pop, r_valid && r_last)
    `RRSE_ASSERT_NOW(a_bk_done_subset, i_clk, i_rst_n, !i_q_status.empty, (r_done & ~i_flags) == '0)

endmodule

[bench/row_run_start_end_encoder_tb.sv]
`timescale 1ns / 1ps

module row_run_start_end_encoder_tb;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    // Cycles without any accepted request before the run is abandoned.
    // The longest planned gap is the long receiver hold.
    localparam int WATCHDOG_LIMIT = 4000;
    // Drain time after the last record: margin for the output register, plus margin
    // for a quiet pixel still in the front end.
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_TARGET = 420;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_PIXELS = 40;

    typedef struct packed {
        rrse_pkg::t_kind kind;
        logic [13:0]     value;
        logic            last;
    } t_record;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_pixel_valid = 1'b0;
    logic        o_pixel_stall;
    logic [7:0]  i_pixel = 8'd0;
    logic        o_record_valid;
    logic        i_record_stall = 1'b0;
    logic [2:0]  o_record_kind;
    logic signed [rrse_pkg::VALUE_W-1:0] o_value;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    row_run_start_end_encoder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_stall  (o_pixel_stall),
        .i_pixel        (i_pixel),
        .o_record_valid (o_record_valid),
        .i_record_stall (i_record_stall),
        .o_record_kind  (o_record_kind),
        .o_value        (o_value),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [7:0] pending_pixels[$];    // pixel requests not yet driven
    t_record    expected_records[$];  // records owed by accepted pixels
    t_record    next_record;

    int pixels_pushed   = 0;          // written by the stimulus process only
    int pixels_issued   = 0;          // written by the driver only
    int pixels_accepted = 0;          // written by the monitor only
    int error_count     = 0;
    int idle_cycles     = 0;

    // Idle percentages, set by the stimulus process
    int tx_idle_pct = 26;
    int rx_idle_pct = 60;

    // Long receiver hold: armed by stimulus, counted down by the stall process
    bit hold_armed = 1'b0;
    bit hold_spent = 1'b0;
    int hold_left  = 0;

    // Predictor copy of the registers and the encoder state
    logic [rrse_pkg::CFG_W-1:0] width_reg  = rrse_pkg::WIDTH_RESET;
    logic [rrse_pkg::CFG_W-1:0] height_reg = rrse_pkg::HEIGHT_RESET;
    int unsigned col_count = 0;
    int unsigned row_count = 0;
    bit          run_open  = 1'b0;

    // Random run generator state
    bit gen_fg   = 1'b0;
    int gen_left = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // A zero register acts as 1, anything past the maximum clamps to it.
    function automatic int unsigned eff_size(input logic [rrse_pkg::CFG_W-1:0] r,
                                             input int unsigned lim);
        if (r == 0)
            return 1;
        if (r > lim)
            return lim;
        return r;
    endfunction

    // Records one pixel causes, in emission order; last flags the final one.
    function automatic void predict_records(input logic [7:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        bit          fg;
        t_record     recs[$];
        w   = eff_size(width_reg, MAX_W);
        h   = eff_size(height_reg, MAX_H);
        fg  = (px != 8'd0);
        col = col_count;

        // first pixel of an image: headers with the effective sizes
        if (col == 0 && row_count == 0) begin
            recs.push_back('{rrse_pkg::KIND_WIDTH, 14'(w), 1'b0});
            recs.push_back('{rrse_pkg::KIND_HEIGHT, 14'(h), 1'b0});
        end

        if (fg && !run_open) begin
            recs.push_back('{rrse_pkg::KIND_START, 14'(col), 1'b0});
            run_open = 1'b1;
        end else if (!fg && run_open) begin
            recs.push_back('{rrse_pkg::KIND_END, 14'(col - 1), 1'b0});
            run_open = 1'b0;
        end

        // row end also catches a width shrunk below the current column
        if (col >= w - 1) begin
            if (run_open) begin
                recs.push_back('{rrse_pkg::KIND_END, 14'(col), 1'b0});
                run_open = 1'b0;
            end
            recs.push_back('{rrse_pkg::KIND_BREAK, rrse_pkg::VALUE_BREAK, 1'b0});
            col_count = 0;
            if (row_count >= h - 1)
                row_count = 0;
            else
                row_count = row_count + 1;
        end else begin
            col_count = col + 1;
        end

        if (recs.size() > 0)
            recs[recs.size() - 1].last = 1'b1;
        foreach (recs[i])
            expected_records.push_back(recs[i]);
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: changes at the falling edge, holds a stalled request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pixel_valid <= 1'b0;
        end else if (i_pixel_valid && pixels_accepted != pixels_issued) begin
            // request still waiting for acceptance: payload stays put
        end else if (pending_pixels.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            i_pixel       <= pending_pixels.pop_front();
            i_pixel_valid <= 1'b1;
            pixels_issued <= pixels_issued + 1;
        end else begin
            i_pixel_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Record stall: random back-pressure plus one long hold so the
    // internal queue fills and the pixel side stalls
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_record_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_record_stall <= 1'b1;
            hold_left      <= hold_left - 1;
        end else if (hold_armed && !hold_spent) begin
            i_record_stall <= 1'b1;
            hold_left      <= LONG_HOLD;
            hold_spent     <= 1'b1;
        end else begin
            i_record_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge, checks records, predicts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_record_valid && !i_record_stall) begin
            if (expected_records.size() == 0) begin
                $error("unexpected record: kind %0d value %0d last %0d",
                       o_record_kind, o_value, o_last);
                error_count++;
            end else begin
                next_record = expected_records.pop_front();
                if (o_record_kind !== next_record.kind) begin
                    $error("record_kind: expected %0d, actual %0d",
                           next_record.kind, o_record_kind);
                    error_count++;
                end
                if (o_value !== next_record.value) begin
                    $error("value: expected %0d, actual %0d",
                           $signed(next_record.value), o_value);
                    error_count++;
                end
                if (o_last !== next_record.last) begin
                    $error("last: expected %0d, actual %0d", next_record.last, o_last);
                    error_count++;
                end
            end
        end
        if (i_rst_n && i_pixel_valid && !o_pixel_stall) begin
            predict_records(i_pixel);
            pixels_accepted <= pixels_accepted + 1;
        end
    end

    // Watchdog: any accepted request on either channel or the config port, or reset, resets it
    always @(posedge i_clk) begin
        if ((i_pixel_valid && !o_pixel_stall) || (o_record_valid && !i_record_stall) ||
            (psel && penable) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Write one register, then read it back.
    task automatic cfg_write(input rrse_pkg::t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == rrse_pkg::REG_IMAGE_WIDTH)
            width_reg = data[rrse_pkg::CFG_W-1:0];
        else
            height_reg = data[rrse_pkg::CFG_W-1:0];
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32-rrse_pkg::CFG_W){1'b0}}, data[rrse_pkg::CFG_W-1:0]}) begin
            $error("prdata: expected %0d, actual %0d", data[rrse_pkg::CFG_W-1:0], prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_pixel(input logic [7:0] px);
        pending_pixels.push_back(px);
        pixels_pushed++;
    endtask

    // Sender pauses until every pixel is in and every record is out,
    // then lets a quiet pixel drain through the front end.
    task automatic wait_idle();
        while (pixels_accepted != pixels_pushed || expected_records.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly small sizes so rows and images turn over often; a few zero,
    // clamped and oversized values, sometimes with junk above bit 12.
    function automatic logic [31:0] pick_size(input int small_max);
        logic [31:0] v;
        case ($urandom_range(19))
            0:       v = 0;
            1:       v = $urandom_range(MAX_W + 1, 8191);
            2:       v = MAX_W;
            3, 4, 5: v = $urandom_range(small_max + 1, 64);
            default: v = $urandom_range(1, small_max);
        endcase
        if ($urandom_range(3) == 0)
            v = v | ($urandom << rrse_pkg::CFG_W);
        return v;
    endfunction

    // Pixels as runs of random length with random foreground values,
    // now and then pure per-pixel noise.
    task automatic queue_pixels(input int n);
        for (int i = 0; i < n; i++) begin
            if (gen_left == 0) begin
                gen_fg   = ($urandom_range(9) < 7) ? !gen_fg : gen_fg;
                gen_left = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 8);
            end
            gen_left--;
            if ($urandom_range(9) == 0)
                push_pixel(($urandom_range(1) == 1) ? 8'($urandom_range(1, 255)) : 8'd0);
            else
                push_pixel(gen_fg ? 8'($urandom_range(1, 255)) : 8'd0);
        end
    endtask

    // Alternating foreground and background: every pixel owes a record,
    // so a held receiver fills the queue quickly.
    task automatic queue_toggling(input int n);
        for (int i = 0; i < n; i++)
            push_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int random_items;
        int phase;
        int n;
        random_items = 0;
        phase        = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes 640x480: headers, run start, end before a gap, new run
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h01);
        push_pixel(8'h00);
        push_pixel(8'h80);

        // Zero sizes act as 1x1; the open run is closed by the shrunk width
        // and every pixel is then a whole image of its own
        wait_idle();
        cfg_write(rrse_pkg::REG_IMAGE_WIDTH, 32'd0);
        cfg_write(rrse_pkg::REG_IMAGE_HEIGHT, 32'd0);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'h55);
        push_pixel(8'hAA);

        // Oversized registers clamp to the maximum in the headers
        wait_idle();
        cfg_write(rrse_pkg::REG_IMAGE_WIDTH, 32'd8191);
        cfg_write(rrse_pkg::REG_IMAGE_HEIGHT, 32'd4097);
        push_pixel(8'h00);
        push_pixel(8'h7F);
        push_pixel(8'hFE);
        push_pixel(8'h00);

        // Exact maximum width, height of one
        wait_idle();
        cfg_write(rrse_pkg::REG_IMAGE_WIDTH, MAX_W);
        cfg_write(rrse_pkg::REG_IMAGE_HEIGHT, 32'd1);
        push_pixel(8'h10);

        // Shrink mid-row with a run open, then short rows and an image wrap
        wait_idle();
        cfg_write(rrse_pkg::REG_IMAGE_WIDTH, 32'd3);
        cfg_write(rrse_pkg::REG_IMAGE_HEIGHT, 32'd2);
        push_pixel(8'h00);
        push_pixel(8'h20);
        push_pixel(8'h40);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'h08);
        push_pixel(8'h04);

        // Random phases: receiver-heavy idling, then sender-heavy, then none
        while (random_items < RANDOM_TARGET) begin
            wait_idle();
            cfg_write(rrse_pkg::REG_IMAGE_WIDTH, pick_size(12));
            cfg_write(rrse_pkg::REG_IMAGE_HEIGHT, pick_size(4));
            case (random_items * 3 / RANDOM_TARGET)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 60;
                end
                1: begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 3) begin
                // one long receiver hold while the sender keeps offering
                hold_armed = 1'b1;
                n = HOLD_PIXELS;
                queue_toggling(n);
            end else begin
                n = $urandom_range(8, 40);
                queue_pixels(n);
            end
            random_items += n;
            phase++;
        end

        wait_idle();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
